// ===== hw/rtl/macd_pkg.sv =====
// ----------------------------------------------------------------------------
// MACD package
// Shared widths, register codes, reset values and control word types of the
// MACD indicator core.
// ----------------------------------------------------------------------------
package macd_pkg;

  localparam int PRICE_BITS      = 32;
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int ALPHA_BITS      = ALPHA_FRAC_BITS + 1;
  localparam int SIG_BITS        = PRICE_BITS + 1;
  localparam int DIFF_BITS       = PRICE_BITS + 2;
  localparam int PROD_BITS       = DIFF_BITS + ALPHA_BITS + 1;
  localparam int HIST_BITS       = PRICE_BITS + 3;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = SIG_BITS;
  localparam int STEP_BITS       = 4;

  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};

  localparam logic [ALPHA_BITS-1:0] SHORT_ALPHA_RST  = ALPHA_BITS'(10082);
  localparam logic [ALPHA_BITS-1:0] LONG_ALPHA_RST   = ALPHA_BITS'(4855);
  localparam logic [ALPHA_BITS-1:0] SIGNAL_ALPHA_RST = ALPHA_BITS'(13107);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SHORT_ALPHA  = 3'd0,
    REG_LONG_ALPHA   = 3'd1,
    REG_SIGNAL_ALPHA = 3'd2,
    REG_SHORT_SEED   = 3'd3,
    REG_LONG_SEED    = 3'd4,
    REG_SIGNAL_SEED  = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEL_SHORT  = 2'd0,
    SEL_LONG   = 2'd1,
    SEL_SIGNAL = 2'd2
  } ema_sel_t;

  // One microcode word.
  typedef struct packed {
    logic     diff_en;
    ema_sel_t diff_sel;
    logic     mul_en;
    ema_sel_t mul_sel;
    logic     upd_en;
    ema_sel_t upd_sel;
    logic     macd_en;
    logic     out_en;
    logic     wait_in;
    logic     wait_out;
    logic     last;
  } ucode_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic     start;
    logic     diff_en;
    ema_sel_t diff_sel;
    logic     mul_en;
    ema_sel_t mul_sel;
    logic     upd_en;
    ema_sel_t upd_sel;
    logic     macd_en;
    logic     out_load;
  } dp_ctrl_t;

endpackage

// ===== hw/rtl/macd_indicator_stream_core.sv =====
// ----------------------------------------------------------------------------
// MACD indicator stream core
// Short, long and signal EMAs of a Q16.16 price stream with MACD and histogram.
// ----------------------------------------------------------------------------
// Each request is accepted in step 0 and then runs through ten microcode
// steps, set by the single multiplier that the short, long and signal EMA
// updates share in turn (difference, product, accumulate for each). The
// result sits in an output register, so the next request is accepted while
// a finished result waits; the final step stalls only if a new result is
// ready before the previous one has been taken. Seeds are loaded at the
// first request after reset and whenever reseed is set.
module macd_indicator_stream_core (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  logic [macd_pkg::CFG_IDX_BITS-1:0]            cfg_addr,
  input  logic [macd_pkg::CFG_DATA_BITS-1:0]           cfg_data,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [macd_pkg::PRICE_BITS-1:0]              close_price,
  input  logic                                         reseed,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [macd_pkg::PRICE_BITS-1:0]              short_ema,
  output logic [macd_pkg::PRICE_BITS-1:0]              long_ema,
  output logic signed [macd_pkg::SIG_BITS-1:0]         macd_value,
  output logic signed [macd_pkg::SIG_BITS-1:0]         signal_value,
  output logic signed [macd_pkg::HIST_BITS-1:0]        histogram
);

  macd_pkg::dp_ctrl_t ctrl;

  macd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctrl      (ctrl)
  );

  macd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .close_price  (close_price),
    .reseed       (reseed),
    .ctrl         (ctrl),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .short_ema    (short_ema),
    .long_ema     (long_ema),
    .macd_value   (macd_value),
    .signal_value (signal_value),
    .histogram    (histogram)
  );

endmodule

// ===== hw/rtl/macd_seq.sv =====
// ----------------------------------------------------------------------------
// MACD sequencer
// Step counter and microcode table that drive the shared EMA datapath.
// ----------------------------------------------------------------------------
module macd_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_valid,
  input  logic                 out_ready,
  output logic                 in_ready,
  output macd_pkg::dp_ctrl_t   ctrl
);

  logic [macd_pkg::STEP_BITS-1:0] step;
  logic [macd_pkg::STEP_BITS-1:0] step_next;
  macd_pkg::ucode_t               uword;
  logic                           hold;

  always_comb begin
    uword = '0;
    uword.diff_sel = macd_pkg::SEL_SHORT;
    uword.mul_sel  = macd_pkg::SEL_SHORT;
    uword.upd_sel  = macd_pkg::SEL_SHORT;
    case (step)
      4'd0: begin
        uword.wait_in = 1'b1;
      end
      4'd1: begin
        uword.diff_en  = 1'b1;
        uword.diff_sel = macd_pkg::SEL_SHORT;
      end
      4'd2: begin
        uword.mul_en  = 1'b1;
        uword.mul_sel = macd_pkg::SEL_SHORT;
      end
      4'd3: begin
        uword.upd_en   = 1'b1;
        uword.upd_sel  = macd_pkg::SEL_SHORT;
        uword.diff_en  = 1'b1;
        uword.diff_sel = macd_pkg::SEL_LONG;
      end
      4'd4: begin
        uword.mul_en  = 1'b1;
        uword.mul_sel = macd_pkg::SEL_LONG;
      end
      4'd5: begin
        uword.upd_en  = 1'b1;
        uword.upd_sel = macd_pkg::SEL_LONG;
      end
      4'd6: begin
        uword.macd_en = 1'b1;
      end
      4'd7: begin
        uword.diff_en  = 1'b1;
        uword.diff_sel = macd_pkg::SEL_SIGNAL;
      end
      4'd8: begin
        uword.mul_en  = 1'b1;
        uword.mul_sel = macd_pkg::SEL_SIGNAL;
      end
      4'd9: begin
        uword.upd_en  = 1'b1;
        uword.upd_sel = macd_pkg::SEL_SIGNAL;
      end
      4'd10: begin
        uword.out_en   = 1'b1;
        uword.wait_out = 1'b1;
        uword.last     = 1'b1;
      end
      default: begin
        uword.last = 1'b1;
      end
    endcase
  end

  // The first step waits for a request; the last waits while the previous result has not been taken.
  assign hold = (uword.wait_in && !in_valid) ||
                (uword.wait_out && out_valid && !out_ready);

  always_comb begin
    if (hold) begin
      step_next = step;
    end else if (uword.last) begin
      step_next = '0;
    end else begin
      step_next = step + macd_pkg::STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  assign in_ready = uword.wait_in;

  always_comb begin
    ctrl.start    = uword.wait_in && in_valid;
    ctrl.diff_en  = uword.diff_en;
    ctrl.diff_sel = uword.diff_sel;
    ctrl.mul_en   = uword.mul_en;
    ctrl.mul_sel  = uword.mul_sel;
    ctrl.upd_en   = uword.upd_en;
    ctrl.upd_sel  = uword.upd_sel;
    ctrl.macd_en  = uword.macd_en;
    ctrl.out_load = uword.out_en && !hold;
  end

endmodule

// ===== hw/rtl/macd_dp.sv =====
// ----------------------------------------------------------------------------
// MACD datapath
// Configuration registers, EMA state, one shared subtractor, multiplier and
// accumulator, and the result register.
// ----------------------------------------------------------------------------
module macd_dp (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  logic [macd_pkg::CFG_IDX_BITS-1:0]            cfg_addr,
  input  logic [macd_pkg::CFG_DATA_BITS-1:0]           cfg_data,
  input  logic [macd_pkg::PRICE_BITS-1:0]              close_price,
  input  logic                                         reseed,
  input  macd_pkg::dp_ctrl_t                           ctrl,
  input  logic                                         out_ready,
  output logic                                         out_valid,
  output logic [macd_pkg::PRICE_BITS-1:0]              short_ema,
  output logic [macd_pkg::PRICE_BITS-1:0]              long_ema,
  output logic signed [macd_pkg::SIG_BITS-1:0]         macd_value,
  output logic signed [macd_pkg::SIG_BITS-1:0]         signal_value,
  output logic signed [macd_pkg::HIST_BITS-1:0]        histogram
);

  logic [macd_pkg::ALPHA_BITS-1:0]        short_alpha;
  logic [macd_pkg::ALPHA_BITS-1:0]        long_alpha;
  logic [macd_pkg::ALPHA_BITS-1:0]        signal_alpha;
  logic [macd_pkg::PRICE_BITS-1:0]        short_seed;
  logic [macd_pkg::PRICE_BITS-1:0]        long_seed;
  logic signed [macd_pkg::SIG_BITS-1:0]   signal_seed;
  logic [macd_pkg::ALPHA_BITS-1:0]        alpha_wr;

  logic                                   seed_pending;
  logic [macd_pkg::PRICE_BITS-1:0]        price;
  logic [macd_pkg::PRICE_BITS-1:0]        short_avg;
  logic [macd_pkg::PRICE_BITS-1:0]        long_avg;
  logic signed [macd_pkg::SIG_BITS-1:0]   signal_avg;
  logic signed [macd_pkg::SIG_BITS-1:0]   macd;
  logic signed [macd_pkg::DIFF_BITS-1:0]  diff;
  logic signed [macd_pkg::PROD_BITS-1:0]  prod;

  logic signed [macd_pkg::DIFF_BITS-1:0]  minuend;
  logic signed [macd_pkg::DIFF_BITS-1:0]  subtrahend;
  logic [macd_pkg::ALPHA_BITS-1:0]        alpha_sel;
  logic signed [macd_pkg::DIFF_BITS-1:0]  prev_sel;
  logic signed [macd_pkg::DIFF_BITS-1:0]  upd_sum;
  logic signed [macd_pkg::DIFF_BITS-1:0]  macd_full;
  logic signed [macd_pkg::DIFF_BITS-1:0]  hist_half;

  // An alpha whose integer bit is set is clamped to one when it is written; higher bits are dropped.
  assign alpha_wr = cfg_data[macd_pkg::ALPHA_FRAC_BITS] ? macd_pkg::ALPHA_ONE :
                    cfg_data[macd_pkg::ALPHA_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      short_alpha  <= macd_pkg::SHORT_ALPHA_RST;
      long_alpha   <= macd_pkg::LONG_ALPHA_RST;
      signal_alpha <= macd_pkg::SIGNAL_ALPHA_RST;
      short_seed   <= '0;
      long_seed    <= '0;
      signal_seed  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        macd_pkg::REG_SHORT_ALPHA:  short_alpha  <= alpha_wr;
        macd_pkg::REG_LONG_ALPHA:   long_alpha   <= alpha_wr;
        macd_pkg::REG_SIGNAL_ALPHA: signal_alpha <= alpha_wr;
        macd_pkg::REG_SHORT_SEED:   short_seed   <= cfg_data[macd_pkg::PRICE_BITS-1:0];
        macd_pkg::REG_LONG_SEED:    long_seed    <= cfg_data[macd_pkg::PRICE_BITS-1:0];
        macd_pkg::REG_SIGNAL_SEED:  signal_seed  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctrl.diff_sel)
      macd_pkg::SEL_LONG: begin
        minuend    = $signed({2'b00, price});
        subtrahend = $signed({2'b00, long_avg});
      end
      macd_pkg::SEL_SIGNAL: begin
        minuend    = macd_pkg::DIFF_BITS'(macd);
        subtrahend = macd_pkg::DIFF_BITS'(signal_avg);
      end
      default: begin
        minuend    = $signed({2'b00, price});
        subtrahend = $signed({2'b00, short_avg});
      end
    endcase
  end

  always_comb begin
    case (ctrl.mul_sel)
      macd_pkg::SEL_LONG:   alpha_sel = long_alpha;
      macd_pkg::SEL_SIGNAL: alpha_sel = signal_alpha;
      default:              alpha_sel = short_alpha;
    endcase
  end

  always_comb begin
    case (ctrl.upd_sel)
      macd_pkg::SEL_LONG:   prev_sel = $signed({2'b00, long_avg});
      macd_pkg::SEL_SIGNAL: prev_sel = macd_pkg::DIFF_BITS'(signal_avg);
      default:              prev_sel = $signed({2'b00, short_avg});
    endcase
  end

  // Taking the product bits above the fraction is an arithmetic shift, so the
  // step rounds toward minus infinity.
  assign upd_sum   = prev_sel +
                     $signed(prod[macd_pkg::ALPHA_FRAC_BITS +: macd_pkg::DIFF_BITS]);
  assign macd_full = $signed({2'b00, short_avg}) - $signed({2'b00, long_avg});
  assign hist_half = macd_pkg::DIFF_BITS'(macd) - macd_pkg::DIFF_BITS'(signal_avg);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_pending <= 1'b1;
      short_avg    <= '0;
      long_avg     <= '0;
      signal_avg   <= '0;
    end else begin
      if (ctrl.start) begin
        seed_pending <= 1'b0;
        if (seed_pending || reseed) begin
          short_avg  <= short_seed;
          long_avg   <= long_seed;
          signal_avg <= signal_seed;
        end
      end
      if (ctrl.upd_en) begin
        case (ctrl.upd_sel)
          macd_pkg::SEL_LONG:   long_avg   <= upd_sum[macd_pkg::PRICE_BITS-1:0];
          macd_pkg::SEL_SIGNAL: signal_avg <= $signed(upd_sum[macd_pkg::SIG_BITS-1:0]);
          default:              short_avg  <= upd_sum[macd_pkg::PRICE_BITS-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      price <= close_price;
    end
    if (ctrl.diff_en) begin
      diff <= minuend - subtrahend;
    end
    if (ctrl.mul_en) begin
      prod <= macd_pkg::PROD_BITS'(diff * $signed({1'b0, alpha_sel}));
    end
    if (ctrl.macd_en) begin
      macd <= $signed(macd_full[macd_pkg::SIG_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      short_ema    <= short_avg;
      long_ema     <= long_avg;
      macd_value   <= macd;
      signal_value <= signal_avg;
      histogram    <= $signed({hist_half, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== tb/tb_macd_indicator_stream_core.sv =====
// ----------------------------------------------------------------------------
// MACD indicator stream core testbench
// Sends closing-price requests through the valid/ready input and compares every
// result against a cycle-free MACD predictor kept inside the bench. Register
// settings change between phases, and the handshakes on both sides stall at
// random.
// ----------------------------------------------------------------------------
module tb_macd_indicator_stream_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 105;

  localparam logic [macd_pkg::CFG_IDX_BITS-1:0] ADDR_UNMAPPED_A = 3'd6;
  localparam logic [macd_pkg::CFG_IDX_BITS-1:0] ADDR_UNMAPPED_B = 3'd7;

  typedef struct packed {
    logic [macd_pkg::PRICE_BITS-1:0] price;
    logic                            reseed;
  } price_req_t;

  typedef struct packed {
    logic [macd_pkg::PRICE_BITS-1:0] short_val;
    logic [macd_pkg::PRICE_BITS-1:0] long_val;
    logic [macd_pkg::SIG_BITS-1:0]   macd_val;
    logic [macd_pkg::SIG_BITS-1:0]   sig_val;
    logic [macd_pkg::HIST_BITS-1:0]  hist_val;
  } macd_res_t;

  logic                                  clk;
  logic                                  rst;
  logic                                  cfg_we;
  logic [macd_pkg::CFG_IDX_BITS-1:0]     cfg_addr;
  logic [macd_pkg::CFG_DATA_BITS-1:0]    cfg_data;
  logic                                  in_valid;
  logic                                  in_ready;
  logic [macd_pkg::PRICE_BITS-1:0]       close_price;
  logic                                  reseed;
  logic                                  out_valid;
  logic                                  out_ready;
  logic [macd_pkg::PRICE_BITS-1:0]       short_ema;
  logic [macd_pkg::PRICE_BITS-1:0]       long_ema;
  logic signed [macd_pkg::SIG_BITS-1:0]  macd_value;
  logic signed [macd_pkg::SIG_BITS-1:0]  signal_value;
  logic signed [macd_pkg::HIST_BITS-1:0] histogram;

  // Register copies and running averages of the predictor.
  logic [macd_pkg::ALPHA_BITS-1:0]      short_alpha, long_alpha, sig_alpha;
  logic [macd_pkg::PRICE_BITS-1:0]      short_seed, long_seed;
  logic signed [macd_pkg::SIG_BITS-1:0] sig_seed;
  longint                               short_lvl, long_lvl, sig_lvl;
  bit                                   seeds_armed;

  price_req_t price_q[$];
  macd_res_t  ema_expect_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int requests_queued;
  int results_seen;
  int mismatches;
  int cycle_count;

  macd_indicator_stream_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .close_price  (close_price),
    .reseed       (reseed),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .short_ema    (short_ema),
    .long_ema     (long_ema),
    .macd_value   (macd_value),
    .signal_value (signal_value),
    .histogram    (histogram)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // One EMA step; the arithmetic shift floors toward minus infinity.
  function automatic longint ema_step(input longint prev, input longint target,
                                      input logic [macd_pkg::ALPHA_BITS-1:0] a);
    longint k;
    k = (a > macd_pkg::ALPHA_ONE) ? longint'(macd_pkg::ALPHA_ONE) : longint'(a);
    return prev + (((target - prev) * k) >>> macd_pkg::ALPHA_FRAC_BITS);
  endfunction

  task automatic advance_macd(input logic [macd_pkg::PRICE_BITS-1:0] price,
                              input logic rs);
    macd_res_t r;
    longint    x, m, h;
    x = longint'(price);
    if (seeds_armed || rs) begin
      short_lvl   = longint'(short_seed);
      long_lvl    = longint'(long_seed);
      sig_lvl     = longint'(sig_seed);
      seeds_armed = 1'b0;
    end
    short_lvl = ema_step(short_lvl, x, short_alpha);
    long_lvl  = ema_step(long_lvl, x, long_alpha);
    m         = short_lvl - long_lvl;
    sig_lvl   = ema_step(sig_lvl, m, sig_alpha);
    h         = 2 * (m - sig_lvl);
    r.short_val = short_lvl[macd_pkg::PRICE_BITS-1:0];
    r.long_val  = long_lvl[macd_pkg::PRICE_BITS-1:0];
    r.macd_val  = m[macd_pkg::SIG_BITS-1:0];
    r.sig_val   = sig_lvl[macd_pkg::SIG_BITS-1:0];
    r.hist_val  = h[macd_pkg::HIST_BITS-1:0];
    ema_expect_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what,
                                 input logic [macd_pkg::HIST_BITS-1:0] got,
                                 input logic [macd_pkg::HIST_BITS-1:0] want);
    mismatches++;
    $display("mismatch in %s at result %0d: got %h, expected %h",
             what, results_seen, got, want);
  endtask

  function automatic void queue_price(input logic [macd_pkg::PRICE_BITS-1:0] p,
                                      input logic rs);
    price_req_t req;
    req.price  = p;
    req.reseed = rs;
    price_q.push_back(req);
    requests_queued++;
  endfunction

  // Keeps the write enable high across back-to-back writes; close_writes drops it.
  task automatic write_reg(input logic [macd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [macd_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    case (idx)
      macd_pkg::REG_SHORT_ALPHA:  short_alpha = data[macd_pkg::ALPHA_BITS-1:0];
      macd_pkg::REG_LONG_ALPHA:   long_alpha  = data[macd_pkg::ALPHA_BITS-1:0];
      macd_pkg::REG_SIGNAL_ALPHA: sig_alpha   = data[macd_pkg::ALPHA_BITS-1:0];
      macd_pkg::REG_SHORT_SEED:   short_seed  = data[macd_pkg::PRICE_BITS-1:0];
      macd_pkg::REG_LONG_SEED:    long_seed   = data[macd_pkg::PRICE_BITS-1:0];
      macd_pkg::REG_SIGNAL_SEED:  sig_seed    = data[macd_pkg::SIG_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (results_seen != requests_queued) @(posedge clk);
  endtask

  // Mostly period-style alphas, with the extremes and raw patterns mixed in.
  function automatic logic [macd_pkg::CFG_DATA_BITS-1:0] pick_alpha();
    case ($urandom_range(5))
      0:       return '0;
      1:       return macd_pkg::CFG_DATA_BITS'(macd_pkg::ALPHA_ONE);
      2:       return {1'($urandom_range(1)), 32'($urandom())};
      default: return macd_pkg::CFG_DATA_BITS'(131072 / ($urandom_range(200, 2) + 1));
    endcase
  endfunction

  function automatic logic [macd_pkg::CFG_DATA_BITS-1:0] pick_word();
    return {1'($urandom_range(1)), 32'($urandom())};
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Request driver: a new request is offered only once the current one is taken.
  always @(posedge clk) begin : drv
    price_req_t nxt;
    if (!rst) begin
      if (in_valid && in_ready)
        advance_macd(close_price, reseed);
      if (!in_valid || in_ready) begin
        if (price_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = price_q.pop_front();
          in_valid    <= 1'b1;
          close_price <= nxt.price;
          reseed      <= nxt.reseed;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : mon
    macd_res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (ema_expect_q.size() == 0) begin
          report_mismatch("unexpected result", macd_pkg::HIST_BITS'(short_ema), '0);
        end else begin
          want = ema_expect_q.pop_front();
          if (short_ema !== want.short_val)
            report_mismatch("short_ema", macd_pkg::HIST_BITS'(short_ema),
                            macd_pkg::HIST_BITS'(want.short_val));
          if (long_ema !== want.long_val)
            report_mismatch("long_ema", macd_pkg::HIST_BITS'(long_ema),
                            macd_pkg::HIST_BITS'(want.long_val));
          if (macd_value !== want.macd_val)
            report_mismatch("macd_value", macd_pkg::HIST_BITS'(macd_value),
                            macd_pkg::HIST_BITS'(want.macd_val));
          if (signal_value !== want.sig_val)
            report_mismatch("signal_value", macd_pkg::HIST_BITS'(signal_value),
                            macd_pkg::HIST_BITS'(want.sig_val));
          if (histogram !== want.hist_val)
            report_mismatch("histogram", histogram, want.hist_val);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : main
    longint lvl;
    longint p;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    close_price = '0;
    reseed      = 1'b0;
    out_ready   = 1'b0;
    short_alpha = macd_pkg::SHORT_ALPHA_RST;
    long_alpha  = macd_pkg::LONG_ALPHA_RST;
    sig_alpha   = macd_pkg::SIGNAL_ALPHA_RST;
    short_seed  = '0;
    long_seed   = '0;
    sig_seed    = '0;
    short_lvl   = 0;
    long_lvl    = 0;
    sig_lvl     = 0;
    seeds_armed = 1'b1;
    send_idle_pct   = 22;
    recv_idle_pct   = 66;
    requests_queued = 0;
    results_seen    = 0;
    mismatches      = 0;
    cycle_count     = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // The first request after reset must pick up the seeds without reseed.
    write_reg(macd_pkg::REG_SHORT_SEED, 33'h0_0050_0000);
    write_reg(macd_pkg::REG_LONG_SEED, 33'h0_0040_0000);
    write_reg(macd_pkg::REG_SIGNAL_SEED, 33'h1_FFF0_0000);
    close_writes();
    queue_price(32'h0001_0000, 1'b0);
    queue_price(32'hFFFF_FFFF, 1'b0);
    queue_price(32'h0000_0000, 1'b0);
    queue_price(32'hFFFF_FFFF, 1'b0);
    queue_price(32'h1234_5678, 1'b1);
    queue_price(32'h0000_0000, 1'b0);
    wait_drained();

    // Unit alpha, zero alpha, saturated alpha and the most negative signal seed.
    write_reg(macd_pkg::REG_SHORT_ALPHA, macd_pkg::CFG_DATA_BITS'(macd_pkg::ALPHA_ONE));
    write_reg(macd_pkg::REG_LONG_ALPHA, '0);
    write_reg(macd_pkg::REG_SIGNAL_ALPHA, 33'h0_0001_FFFF);
    write_reg(macd_pkg::REG_SHORT_SEED, 33'h0_FFFF_FFFF);
    write_reg(macd_pkg::REG_LONG_SEED, '0);
    write_reg(macd_pkg::REG_SIGNAL_SEED, 33'h1_0000_0000);
    write_reg(ADDR_UNMAPPED_A, 33'h1_FFFF_FFFF);
    write_reg(ADDR_UNMAPPED_B, 33'h0_0000_0001);
    close_writes();
    queue_price(32'h0000_0000, 1'b1);
    queue_price(32'hFFFF_FFFF, 1'b0);
    queue_price(32'h0000_0000, 1'b0);
    queue_price(32'h8000_0000, 1'b1);
    wait_drained();

    write_reg(macd_pkg::REG_SHORT_ALPHA, '0);
    write_reg(macd_pkg::REG_LONG_ALPHA, 33'h0_0001_0001);
    write_reg(macd_pkg::REG_SIGNAL_ALPHA, '0);
    write_reg(macd_pkg::REG_SHORT_SEED, '0);
    write_reg(macd_pkg::REG_LONG_SEED, 33'h0_FFFF_FFFF);
    write_reg(macd_pkg::REG_SIGNAL_SEED, 33'h0_FFFF_FFFF);
    close_writes();
    queue_price(32'hFFFF_FFFF, 1'b1);
    queue_price(32'h0000_0000, 1'b0);
    queue_price(32'hFFFF_FFFF, 1'b0);
    queue_price(32'h0000_0001, 1'b1);
    wait_drained();

    // Bits above each register's width must be dropped.
    write_reg(macd_pkg::REG_SHORT_ALPHA, 33'h0_0002_0001);
    write_reg(macd_pkg::REG_LONG_ALPHA, 33'h0_0000_0001);
    write_reg(macd_pkg::REG_SIGNAL_ALPHA, 33'h1_0000_0001);
    write_reg(macd_pkg::REG_SHORT_SEED, 33'h1_8000_0000);
    write_reg(macd_pkg::REG_LONG_SEED, 33'h0_7FFF_FFFF);
    write_reg(macd_pkg::REG_SIGNAL_SEED, 33'h1_FFFF_FFFF);
    close_writes();
    queue_price(32'h0000_0000, 1'b1);
    queue_price(32'hFFFF_FFFF, 1'b0);
    queue_price(32'h7FFF_FFFF, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph == 2) begin
        send_idle_pct = 66;
        recv_idle_pct = 22;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(macd_pkg::REG_SHORT_ALPHA, pick_alpha());
      write_reg(macd_pkg::REG_LONG_ALPHA, pick_alpha());
      write_reg(macd_pkg::REG_SIGNAL_ALPHA, pick_alpha());
      write_reg(macd_pkg::REG_SHORT_SEED, pick_word());
      write_reg(macd_pkg::REG_LONG_SEED, pick_word());
      write_reg(macd_pkg::REG_SIGNAL_SEED, pick_word());
      if ($urandom_range(1) == 1)
        write_reg($urandom_range(1) ? ADDR_UNMAPPED_A : ADDR_UNMAPPED_B, pick_word());
      close_writes();

      // A price series wandering around a level, with jumps and the odd reseed.
      lvl = longint'($urandom());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(3) == 0) begin
          p = longint'($urandom());
        end else begin
          lvl = lvl + longint'($urandom_range(2097152)) - 1048576;
          if (lvl < 0)
            lvl = 0;
          if (lvl > 64'd4294967295)
            lvl = 64'd4294967295;
          p = lvl;
        end
        queue_price(p[macd_pkg::PRICE_BITS-1:0], $urandom_range(24) == 0);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/macd_pkg.sv
hw/rtl/macd_seq.sv
hw/rtl/macd_dp.sv
hw/rtl/macd_indicator_stream_core.sv
tb/tb_macd_indicator_stream_core.sv
